[rtl/lzw_byte_encoder_macros.svh]
`ifndef LZW_BYTE_ENCODER_MACROS_SVH
`define LZW_BYTE_ENCODER_MACROS_SVH

// Invariant checked at every edge out of reset.
`define LBE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define LBE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lbe_pkg.sv]
package lbe_pkg;

  localparam int CODE_BITS     = 12;
  localparam int TABLE_SIZE    = 1 << CODE_BITS;
  localparam int HASH_BITS     = CODE_BITS + 1;
  localparam int HASH_SIZE     = 1 << HASH_BITS;
  localparam int KEY_BITS      = CODE_BITS + 8;
  localparam int FIRST_LEARNED = 256;
  localparam logic [7:0] BYTE_FLIP = 8'h80;

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [CODE_BITS:0]   free_t;
  typedef logic [HASH_BITS-1:0] hash_t;
  typedef logic [KEY_BITS-1:0]  key_t;

  typedef struct packed {
    key_t  key;
    hash_t slot;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_req_t;

  typedef struct packed {
    code_t code;
    logic  out_last;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIRST,
    ST_LOOKUP,
    ST_ENTRY,
    ST_CHECK,
    ST_EMIT_MISS,
    ST_EMIT_LAST
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic set_first;
    logic take_hit;
    logic probe_next;
    logic insert;
    logic push_miss;
    logic push_last;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic cur_valid;
    logic last;
    logic owned;
    logic hit;
    logic out_space;
  } sts_t;

endpackage

[rtl/lbe_ram.sv]
module lbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lbe_ctrl.sv]
`include "lzw_byte_encoder_macros.svh"

module lbe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lbe_pkg::sts_t sts,
  output lbe_pkg::cmd_t cmd
);

  import lbe_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = sts.cur_valid ? ST_LOOKUP : ST_FIRST;
      end
      ST_FIRST: begin
        state_next = sts.last ? ST_EMIT_LAST : ST_IDLE;
      end
      ST_LOOKUP: state_next = ST_ENTRY;
      ST_ENTRY:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (sts.hit) begin
          state_next = sts.last ? ST_EMIT_LAST : ST_IDLE;
        end else if (sts.owned) begin
          state_next = ST_LOOKUP;
        end else begin
          state_next = ST_EMIT_MISS;
        end
      end
      ST_EMIT_MISS: begin
        if (sts.out_space) state_next = sts.last ? ST_EMIT_LAST : ST_IDLE;
      end
      ST_EMIT_LAST: begin
        if (sts.out_space) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_FIRST: cmd.set_first = 1'b1;
      ST_LOOKUP, ST_ENTRY: ;
      ST_CHECK: begin
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
        end else if (sts.owned) begin
          cmd.probe_next = 1'b1;
        end else begin
          cmd.insert = 1'b1;
        end
      end
      ST_EMIT_MISS: cmd.push_miss = sts.out_space;
      ST_EMIT_LAST: cmd.push_last = sts.out_space;
      default: ;
    endcase
  end

  `LBE_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state != ST_IDLE, "request accepted but controller stayed idle")
  `LBE_ASSERT_ALWAYS(a_one_action, ($onehot0({cmd.take_hit, cmd.probe_next, cmd.insert, cmd.push_miss, cmd.push_last})), "conflicting datapath commands")
  `LBE_ASSERT_NEXT(a_last_ends_item, cmd.push_last, state == ST_IDLE, "final code did not return to idle")

endmodule

[rtl/lbe_datapath.sv]
`include "lzw_byte_encoder_macros.svh"

module lbe_datapath (
  input  logic              clk,
  input  logic              rst,
  input  lbe_pkg::in_req_t  in_req,
  input  lbe_pkg::cmd_t     cmd,
  output lbe_pkg::sts_t     sts,
  output logic              out_valid,
  input  logic              out_ready,
  output lbe_pkg::out_req_t out_req
);

  import lbe_pkg::*;

  logic [7:0] byte_reg;
  logic       last_reg;
  code_t      cur_code;
  logic       cur_valid;
  free_t      next_free;
  hash_t      probe;
  hash_t      clear_addr;

  hash_t      probe_home;
  code_t      single;
  key_t       key_w;
  code_t      slot_code;
  entry_t     entry;
  logic [ENTRY_BITS-1:0] entry_rdata;
  logic       owned;
  logic       hit;
  logic       room;
  logic       out_space;

  logic       hash_we;
  hash_t      hash_waddr;
  code_t      hash_wdata;
  logic       entry_we;

  assign single     = code_t'(byte_reg ^ BYTE_FLIP);
  assign key_w      = {cur_code, byte_reg};
  assign probe_home = hash_t'(cur_code) ^ (hash_t'(in_req.in_byte) << (HASH_BITS - 8));
  assign entry      = entry_t'(entry_rdata);
  assign owned      = (slot_code >= code_t'(FIRST_LEARNED))
                      && ({1'b0, slot_code} < next_free)
                      && (entry.slot == probe);
  assign hit        = owned && (entry.key == key_w);
  assign room       = next_free < free_t'(TABLE_SIZE);
  assign out_space  = !out_valid || out_ready;

  assign hash_we    = cmd.clear_step || (cmd.insert && room);
  assign hash_waddr = cmd.clear_step ? clear_addr : probe;
  assign hash_wdata = cmd.clear_step ? '0 : next_free[CODE_BITS-1:0];
  assign entry_we   = cmd.insert && room;

  lbe_ram #(
    .WIDTH(CODE_BITS),
    .DEPTH(HASH_SIZE)
  ) u_slot_ram (
    .clk  (clk),
    .we   (hash_we),
    .waddr(hash_waddr),
    .wdata(hash_wdata),
    .raddr(probe),
    .rdata(slot_code)
  );

  lbe_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(TABLE_SIZE)
  ) u_entry_ram (
    .clk  (clk),
    .we   (entry_we),
    .waddr(next_free[CODE_BITS-1:0]),
    .wdata({key_w, probe}),
    .raddr(slot_code),
    .rdata(entry_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_reg <= in_req.in_byte;
      last_reg <= in_req.in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      probe <= probe_home;
    end else if (cmd.probe_next) begin
      probe <= probe + hash_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_step) begin
      clear_addr <= clear_addr + hash_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_code  <= '0;
      cur_valid <= 1'b0;
    end else if (cmd.set_first) begin
      cur_code  <= single;
      cur_valid <= 1'b1;
    end else if (cmd.take_hit) begin
      cur_code <= slot_code;
    end else if (cmd.push_miss) begin
      cur_code <= single;
    end else if (cmd.push_last) begin
      cur_code  <= '0;
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= free_t'(FIRST_LEARNED);
    end else if (cmd.push_last) begin
      next_free <= free_t'(FIRST_LEARNED);
    end else if (entry_we) begin
      next_free <= next_free + free_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_miss || cmd.push_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_miss || cmd.push_last) begin
      out_req.code     <= cur_code;
      out_req.out_last <= cmd.push_last;
    end
  end

  always_comb begin
    sts.clear_done = clear_addr == '1;
    sts.cur_valid  = cur_valid;
    sts.last       = last_reg;
    sts.owned      = owned;
    sts.hit        = hit;
    sts.out_space  = out_space;
  end

  `LBE_ASSERT_IMP(a_push_has_space, cmd.push_miss || cmd.push_last, !out_valid || out_ready, "result pushed over a pending one")
  `LBE_ASSERT_ALWAYS(a_free_in_range, (next_free >= free_t'(FIRST_LEARNED)) && (next_free <= free_t'(TABLE_SIZE)), "next free code out of range")
  `LBE_ASSERT_NEXT(a_last_restarts, cmd.push_last, (next_free == free_t'(FIRST_LEARNED)) && !cur_valid, "dictionary not restarted after final code")

endmodule

[rtl/lzw_byte_encoder.sv]
// Fixed-width LZW encoder: one byte per request in, CODE_BITS-wide codes out, with the
// final byte of an input flushing the held string as a code marked last. After reset
// the block clears all 2^(CODE_BITS+1) slots of its hash slot memory (8192 at 12-bit
// codes) and takes no byte until that is done. Then a byte that starts an input passes
// through ST_FIRST; any other byte passes through ST_LOOKUP, ST_ENTRY and ST_CHECK for
// each hash probe, then ST_EMIT_MISS if it ends a string, and the final byte of an
// input adds ST_EMIT_LAST for its flushed code. Each probe is two dependent memory
// reads (slot memory, then string memory) and a key compare. Results wait in a
// one-entry output register, so the next byte is taken while a code is still pending;
// a byte that yields two codes holds the input side until the first code leaves.
module lzw_byte_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lbe_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output lbe_pkg::out_req_t out_req
);

  import lbe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lbe_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  lbe_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_req   (in_req),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_req  (out_req)
  );

endmodule
